>>> hdl/ops_pkg.sv
// ----------------------------------------------------------------------------
// ops_pkg
// Shared types, codes and defaults of the obfuscated pattern scanner.
// ----------------------------------------------------------------------------
package ops_pkg;

  localparam int KEY_COUNT_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int RESULTS_MAX     = 4;

  // configuration register indexes
  typedef enum logic {
    REG_SCAN_DECODING  = 1'b0,
    REG_SEARCH_PATTERN = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    DEC_PLAIN     = 2'd0,
    DEC_ROT13     = 2'd1,
    DEC_XOR       = 2'd2,
    DEC_XOR_ROT13 = 2'd3
  } decoding_t;

  typedef enum logic {
    PAT_HTTP = 1'b0,
    PAT_EXE  = 1'b1
  } pattern_t;

  typedef enum logic [1:0] {
    PH_SCAN = 2'd0,
    PH_URL  = 2'd1,
    PH_HALT = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_EXE  = 2'd1,
    KIND_END  = 2'd2
  } result_kind_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [4:0] key;
    logic       last;
  } result_t;

  // one queue entry: the results caused by one accepted byte, first in res[0]
  typedef struct packed {
    logic [1:0]                  last_idx;
    result_t [RESULTS_MAX-1:0]   res;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hdl/ops_front.sv
// ----------------------------------------------------------------------------
// ops_front
// Byte intake: history window, parallel key match, url tracking and grouping
// of the results of each byte for the queue.
// ----------------------------------------------------------------------------
module ops_front #(
  parameter int KEY_COUNT = ops_pkg::KEY_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               start_of_data,
  input  logic               end_of_data,
  input  ops_pkg::q_status_t q_status,
  output logic               push,
  output ops_pkg::group_t    push_group
);
  import ops_pkg::*;

  localparam int KW = $clog2(KEY_COUNT);

  localparam logic [7:0] CH_H     = 8'd104;
  localparam logic [7:0] CH_T     = 8'd116;
  localparam logic [7:0] CH_P     = 8'd112;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_E     = 8'd101;
  localparam logic [7:0] CH_X     = 8'd120;
  localparam logic [7:0] CASE_GAP = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] ROT_STEP = 8'd13;
  localparam logic [7:0] UP_LO    = 8'd64;
  localparam logic [7:0] UP_MID   = 8'd78;
  localparam logic [7:0] UP_HI    = 8'd91;
  localparam logic [7:0] LO_LO    = 8'd96;
  localparam logic [7:0] LO_MID   = 8'd110;
  localparam logic [7:0] LO_HI    = 8'd123;

  function automatic logic [7:0] rot13(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if ((b > UP_LO && b < UP_MID) || (b > LO_LO && b < LO_MID)) begin
      r = b + ROT_STEP;
    end else if ((b > UP_MID - 8'd1 && b < UP_HI) || (b > LO_MID - 8'd1 && b < LO_HI)) begin
      r = b - ROT_STEP;
    end
    return r;
  endfunction

  function automatic logic [7:0] dec_http(input logic [1:0] mode, input logic [7:0] b,
                                          input logic [7:0] k);
    logic [7:0] r;
    case (mode)
      DEC_PLAIN: r = b;
      DEC_ROT13: r = rot13(b);
      DEC_XOR:   r = b ^ k;
      default:   r = rot13(b) ^ k;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] dec_exe(input logic [1:0] mode, input logic [7:0] b,
                                         input logic [7:0] k);
    logic [7:0] r;
    if (mode == DEC_XOR_ROT13) begin
      r = rot13(b ^ k);
    end else begin
      r = dec_http(mode, b, k);
    end
    return r;
  endfunction

  function automatic logic ci(input logic [7:0] c, input logic [7:0] lower);
    return (c == lower) || (c == lower - CASE_GAP);
  endfunction

  // configuration
  logic [1:0] scan_decoding;
  logic       search_pattern;

  // scan state
  logic [7:0]    hist [3];
  logic [1:0]    fill;
  phase_t        phase;
  logic [KW-1:0] found_key;

  logic [7:0]    hist_next [3];
  logic [1:0]    fill_next;
  phase_t        phase_next;
  logic [KW-1:0] found_key_next;

  logic [7:0]     h0, h1, h2;
  logic [1:0]     fill_eff;
  phase_t         phase_eff;
  logic [KW-1:0]  key_eff;
  logic [KEY_COUNT-1:0] hit;
  logic           any_hit;
  logic [KW-1:0]  win;
  logic [7:0]     win8, fkey8, c0, c1, c2, c3, cu;
  logic           accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_decoding  <= DEC_PLAIN;
      search_pattern <= PAT_HTTP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCAN_DECODING:  scan_decoding  <= cfg_data;
        REG_SEARCH_PATTERN: search_pattern <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // start of data clears the window before this byte
  always_comb begin
    if (start_of_data) begin
      h0 = '0;
      h1 = '0;
      h2 = '0;
      fill_eff  = '0;
      phase_eff = PH_SCAN;
      key_eff   = '0;
    end else begin
      h0 = hist[0];
      h1 = hist[1];
      h2 = hist[2];
      fill_eff  = fill;
      phase_eff = phase;
      key_eff   = found_key;
    end
  end

  // every key is tried at once; plain and rot13 use key zero only
  always_comb begin
    logic [7:0] kb;
    logic       allowed, m_http, m_exe;
    for (int k = 0; k < KEY_COUNT; k++) begin
      kb      = 8'(k);
      allowed = scan_decoding[1] ? (k != 0) : (k == 0);
      m_http  = ci(dec_http(scan_decoding, h0, kb), CH_H) &&
                ci(dec_http(scan_decoding, h1, kb), CH_T) &&
                ci(dec_http(scan_decoding, h2, kb), CH_T) &&
                ci(dec_http(scan_decoding, data_byte, kb), CH_P);
      m_exe   = (dec_exe(scan_decoding, h0, kb) == CH_DOT) &&
                ci(dec_exe(scan_decoding, h1, kb), CH_E) &&
                ci(dec_exe(scan_decoding, h2, kb), CH_X) &&
                ci(dec_exe(scan_decoding, data_byte, kb), CH_E);
      hit[k]  = allowed && ((search_pattern == PAT_HTTP) ? m_http : m_exe);
    end
  end

  // lowest matching key wins
  always_comb begin
    win = '0;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (hit[k]) begin
        win = KW'(k);
      end
    end
  end

  assign any_hit = |hit;
  assign win8    = 8'(win);
  assign fkey8   = 8'(key_eff);
  assign c0      = dec_http(scan_decoding, h0, win8);
  assign c1      = dec_http(scan_decoding, h1, win8);
  assign c2      = dec_http(scan_decoding, h2, win8);
  assign c3      = dec_http(scan_decoding, data_byte, win8);
  assign cu      = dec_http(scan_decoding, data_byte, fkey8);

  always_comb begin
    push_group     = '0;
    push           = 1'b0;
    phase_next     = phase_eff;
    found_key_next = key_eff;
    case (phase_eff)
      PH_SCAN: begin
        if (fill_eff == 2'd3 && any_hit) begin
          found_key_next = win;
          if (search_pattern == PAT_HTTP) begin
            push_group.last_idx   = 2'd3;
            push_group.res[0]     = '{KIND_CHAR, c0, win8[4:0], 1'b0};
            push_group.res[1]     = '{KIND_CHAR, c1, win8[4:0], 1'b0};
            push_group.res[2]     = '{KIND_CHAR, c2, win8[4:0], 1'b0};
            push_group.res[3]     = '{KIND_CHAR, c3, win8[4:0], end_of_data};
            phase_next            = end_of_data ? PH_HALT : PH_URL;
          end else begin
            push_group.last_idx   = 2'd0;
            push_group.res[0]     = '{KIND_EXE, 8'd0, win8[4:0], 1'b1};
            phase_next            = PH_HALT;
          end
          push = accept;
        end
      end
      PH_URL: begin
        push = accept;
        if (cu > CASE_GAP && cu < CH_DEL) begin
          push_group.res[0] = '{KIND_CHAR, cu, fkey8[4:0], 1'b0};
          if (end_of_data) begin
            push_group.last_idx = 2'd1;
            push_group.res[1]   = '{KIND_END, 8'd0, fkey8[4:0], 1'b1};
            phase_next          = PH_HALT;
          end
        end else begin
          push_group.res[0] = '{KIND_END, 8'd0, fkey8[4:0], 1'b1};
          phase_next        = PH_HALT;
        end
      end
      default: ;
    endcase
  end

  // shift the window; end of data drops it so no match spans two data sets
  always_comb begin
    hist_next[0] = h1;
    hist_next[1] = h2;
    hist_next[2] = data_byte;
    fill_next    = (fill_eff == 2'd3) ? fill_eff : fill_eff + 2'd1;
    if (end_of_data) begin
      hist_next[0] = '0;
      hist_next[1] = '0;
      hist_next[2] = '0;
      fill_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist[0]   <= '0;
      hist[1]   <= '0;
      hist[2]   <= '0;
      fill      <= '0;
      phase     <= PH_SCAN;
      found_key <= '0;
    end else if (accept) begin
      hist[0]   <= hist_next[0];
      hist[1]   <= hist_next[1];
      hist[2]   <= hist_next[2];
      fill      <= fill_next;
      phase     <= phase_next;
      found_key <= found_key_next;
    end
  end

endmodule

>>> hdl/ops_queue.sv
// ----------------------------------------------------------------------------
// ops_queue
// Short queue of result groups between intake and output.
// ----------------------------------------------------------------------------
module ops_queue #(
  parameter int DEPTH = ops_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ops_pkg::group_t    push_group,
  input  logic               pop,
  output ops_pkg::group_t    head,
  output ops_pkg::q_status_t q_status
);
  import ops_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  group_t        entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign head           = entries[rd_ptr];
  assign q_status.full  = (count == CW'(DEPTH));
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

>>> hdl/ops_back.sv
// ----------------------------------------------------------------------------
// ops_back
// Output side: hands out the results of the head group one per transfer.
// ----------------------------------------------------------------------------
module ops_back (
  input  logic               clk,
  input  logic               rst,
  input  ops_pkg::group_t    head,
  input  ops_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_kind,
  output logic [7:0]         char_value,
  output logic [4:0]         key_value,
  output logic               last_of_report
);
  import ops_pkg::*;

  logic [1:0] sub;
  result_t    cur;

  assign cur            = head.res[sub];
  assign out_valid      = !q_status.empty;
  assign result_kind    = cur.kind;
  assign char_value     = cur.ch;
  assign key_value      = cur.key;
  assign last_of_report = cur.last;
  assign pop            = out_valid && out_ready && (sub == head.last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= '0;
    end else if (out_valid && out_ready) begin
      sub <= pop ? 2'd0 : sub + 2'd1;
    end
  end

endmodule

>>> hdl/obfuscated_pattern_scanner_top.sv
// ----------------------------------------------------------------------------
// obfuscated_pattern_scanner_top
// Scans a byte stream for "http" or ".exe" under plain, rot13 or xor coding.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the result queue has room; results
//   leave one per cycle while the receiver is ready, so from an empty
//   four-entry queue a url match (four results) followed by url bytes back
//   to back holds input until the match's last result leaves.
//   Receiver stalls hold input once QUEUE_DEPTH groups wait.
// Reset (rst, synchronous): clears registers, window, phase and queue at once.
// ----------------------------------------------------------------------------
module obfuscated_pattern_scanner_top #(
  parameter int KEY_COUNT   = ops_pkg::KEY_COUNT_DEF,
  parameter int QUEUE_DEPTH = ops_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // configuration writes
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data,
  // byte input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       start_of_data,
  input  logic       end_of_data,
  // result output
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] result_kind,
  output logic [7:0] char_value,
  output logic [4:0] key_value,
  output logic       last_of_report
);
  import ops_pkg::*;

  // front to queue: one group per byte that causes results
  logic      push;
  group_t    push_group;
  // queue to back: head group; back to queue: drop the head
  group_t    head;
  logic      pop;
  q_status_t q_status;

  // Intake: window, key match and url tracking all settle in the transfer
  // cycle, so the next byte sees the phase this one leaves behind.
  ops_front #(
    .KEY_COUNT (KEY_COUNT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .start_of_data (start_of_data),
    .end_of_data   (end_of_data),
    .q_status      (q_status),
    .push          (push),
    .push_group    (push_group)
  );

  // Queue: parts intake from output so each side can stall on its own.
  ops_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  // Output: walk the head group one result per transfer, then drop it.
  ops_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .char_value     (char_value),
    .key_value      (key_value),
    .last_of_report (last_of_report)
  );

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full))
    else $error("group pushed into a full queue");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind != KIND_CHAR) |-> last_of_report)
    else $error("marker result not closing its report");

  a_marker_char_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind != KIND_CHAR) |-> (char_value == 8'd0))
    else $error("marker result carries a character");
`endif

endmodule

>>> test/tb_obfuscated_pattern_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_obfuscated_pattern_scanner_top
// Self-checking bench for the pattern scanner. A scoreboard object tracks the
// window, phase and latched key of the block. It predicts every url letter,
// exe report and end marker from the bytes as they transfer. The bench checks
// each result transfer against the oldest prediction. Stimulus starts with
// hand-picked data sets and then moves to random data sets. Each random
// phase uses its own decoding and search setting and one of four idling
// patterns on either side of the block.
// ----------------------------------------------------------------------------
module tb_obfuscated_pattern_scanner_top;
  import ops_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 4;
  localparam int          LONG_HOLD      = 80;
  localparam int unsigned PHASE_BYTES    = 18;

  // decoding and search setting of each random phase: all eight pairings
  localparam decoding_t PHASE_DEC [8] = '{DEC_PLAIN, DEC_XOR_ROT13, DEC_ROT13, DEC_XOR,
                                          DEC_XOR_ROT13, DEC_PLAIN, DEC_XOR, DEC_ROT13};
  localparam pattern_t  PHASE_PAT [8] = '{PAT_HTTP, PAT_EXE, PAT_EXE, PAT_HTTP,
                                          PAT_HTTP, PAT_EXE, PAT_EXE, PAT_HTTP};
  // idling patterns: none, sender only, receiver only, both
  localparam int unsigned GAP_PCT   [4] = '{0, 56, 0, 26};
  localparam int unsigned STALL_PCT [4] = '{0, 0, 56, 26};

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the scanner and holds the results still owed by it
  // --------------------------------------------------------------------------
  class scan_tracker;
    decoding_t   decoding;
    pattern_t    pattern;
    logic [7:0]  hist [3];   // raw bytes, index 2 newest
    int unsigned fill;
    phase_t      phase;
    logic [4:0]  key;
    result_t     pending [$];
    int unsigned mismatches;

    function new();
      decoding   = DEC_PLAIN;
      pattern    = PAT_HTTP;
      phase      = PH_SCAN;
      key        = '0;
      mismatches = 0;
      clear_window();
    endfunction

    static function logic [7:0] rot13(logic [7:0] b);
      if ((b > 8'd64 && b < 8'd78) || (b > 8'd96 && b < 8'd110)) return b + 8'd13;
      if ((b > 8'd77 && b < 8'd91) || (b > 8'd109 && b < 8'd123)) return b - 8'd13;
      return b;
    endfunction

    function void clear_window();
      hist = '{default: '0};
      fill = 0;
    endfunction

    // exe_side picks the order of rot13 and xor in the combined mode
    function logic [7:0] decode(logic [7:0] b, logic [4:0] k, bit exe_side);
      logic [7:0] kx;
      kx = {3'b000, k};
      case (decoding)
        DEC_PLAIN: return b;
        DEC_ROT13: return rot13(b);
        DEC_XOR:   return b ^ kx;
        default:   return exe_side ? rot13(b ^ kx) : (rot13(b) ^ kx);
      endcase
    endfunction

    function bit letter_is(logic [7:0] c, logic [7:0] lower);
      return c == lower || c == lower - 8'd32;
    endfunction

    function void add(result_kind_t kind, logic [7:0] ch, logic [4:0] k, logic last);
      result_t r;
      r.kind = kind;
      r.ch   = ch;
      r.key  = k;
      r.last = last;
      pending.push_back(r);
    endfunction

    function void write_reg(reg_index_t idx, logic [1:0] value);
      if (idx == REG_SCAN_DECODING) decoding = decoding_t'(value);
      else pattern = pattern_t'(value[0]);
    endfunction

    // one byte transfer: work out every result it owes
    function void take_byte(logic [7:0] b, logic sod, logic eod);
      logic [7:0] c [4];
      logic [7:0] u;
      int         k_first;
      int         k_last;
      bit         hit;
      if (sod) begin
        clear_window();
        phase = PH_SCAN;
        key   = '0;
      end
      if (phase == PH_SCAN && fill >= 3) begin
        k_first = decoding[1] ? 1 : 0;
        k_last  = decoding[1] ? KEY_COUNT_DEF - 1 : 0;
        hit     = 1'b0;
        // lowest key wins, so stop at the first hit
        for (int k = k_first; k <= k_last && !hit; k++) begin
          for (int i = 0; i < 4; i++)
            c[i] = decode((i < 3) ? hist[i] : b, 5'(k), pattern == PAT_EXE);
          if (pattern == PAT_HTTP) begin
            if (letter_is(c[0], "h") && letter_is(c[1], "t") &&
                letter_is(c[2], "t") && letter_is(c[3], "p")) begin
              hit = 1'b1;
              key = 5'(k);
              for (int i = 0; i < 4; i++) add(KIND_CHAR, c[i], key, eod && i == 3);
              phase = eod ? PH_HALT : PH_URL;
            end
          end else if (c[0] == "." && letter_is(c[1], "e") &&
                       letter_is(c[2], "x") && letter_is(c[3], "e")) begin
            hit = 1'b1;
            key = 5'(k);
            add(KIND_EXE, 8'd0, key, 1'b1);
            phase = PH_HALT;
          end
        end
      end else if (phase == PH_URL) begin
        // url bytes follow the current decoding with the latched key
        u = decode(b, key, 1'b0);
        if (u > 8'd32 && u < 8'd127) begin
          add(KIND_CHAR, u, key, 1'b0);
          if (eod) begin
            add(KIND_END, 8'd0, key, 1'b1);
            phase = PH_HALT;
          end
        end else begin
          add(KIND_END, 8'd0, key, 1'b1);
          phase = PH_HALT;
        end
      end
      hist[0] = hist[1];
      hist[1] = hist[2];
      hist[2] = b;
      if (fill < 3) fill++;
      // no match may straddle two data sets
      if (eod) clear_window();
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("result with none owed: result_kind %0d char_value %0d key_value %0d",
               got.kind, got.ch, got.key);
        mismatches++;
      end else begin
        want = pending.pop_front();
        compare_field("result_kind", want.kind, got.kind);
        compare_field("char_value", want.ch, got.ch);
        compare_field("key_value", want.key, got.key);
        compare_field("last_of_report", want.last, got.last);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block itself; every input is known from time zero
  // --------------------------------------------------------------------------
  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       cfg_we         = 1'b0;
  logic       cfg_index      = 1'b0;
  logic [1:0] cfg_data       = 2'd0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte      = 8'd0;
  logic       start_of_data  = 1'b0;
  logic       end_of_data    = 1'b0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [1:0] result_kind;
  logic [7:0] char_value;
  logic [4:0] key_value;
  logic       last_of_report;

  scan_tracker tracker = new();

  int unsigned gap_pct       = 0;
  int unsigned stall_pct     = 0;
  int unsigned bytes_sent    = 0;
  int unsigned hold_requests = 0;   // bumped by the stimulus to ask for a long hold
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  obfuscated_pattern_scanner_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .start_of_data  (start_of_data),
    .end_of_data    (end_of_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .char_value     (char_value),
    .key_value      (key_value),
    .last_of_report (last_of_report)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random, or hold off for a long stretch on request so
  // that the result queue fills and the block stops taking bytes.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_result({result_kind, char_value, key_value, last_of_report});
  end

  // Watchdog: end the run if nothing transfers for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one byte, after a random gap, and hold it until it transfers.
  // Valid is left high on return; the next call or settle() decides its fate.
  task automatic send_byte(logic [7:0] b, logic sod, logic eod);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    start_of_data <= sod;
    end_of_data   <= eod;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_byte(b, sod, eod);
    bytes_sent++;
  endtask

  task automatic send_text(string s, logic sod, logic eod);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], sod && i == 0, eod && i == s.len() - 1);
  endtask

  // Drop valid, wait until every owed result has arrived, then allow for a
  // byte that is still in the pipe without owing anything.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only call this while the block is idle.
  task automatic write_reg(reg_index_t idx, logic [1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    tracker.write_reg(idx, value);
    cfg_we <= 1'b0;
  endtask

  // Inverse of the block's decoding, so that a chosen plain text comes out.
  function automatic logic [7:0] encode(logic [7:0] c, logic [7:0] k, bit exe_side);
    case (tracker.decoding)
      DEC_PLAIN: return c;
      DEC_ROT13: return scan_tracker::rot13(c);
      DEC_XOR:   return c ^ k;
      default:   return exe_side ? (scan_tracker::rot13(c) ^ k)
                                 : scan_tracker::rot13(c ^ k);
    endcase
  endfunction

  // One data set: noise lead-in, then mostly a well-formed pattern under the
  // current decoding (sometimes broken, sometimes plain noise), url text for http, a
  // terminator and trailing bytes. A few sets are left open; the next one
  // starts afresh with start of data.
  task automatic send_record();
    logic [7:0]  raw [$];
    logic [7:0]  word [4];
    logic [7:0]  k;
    logic [7:0]  c;
    bit          exe_side;
    bit          closed;
    int unsigned shape;
    int unsigned ending;
    exe_side = (tracker.pattern == PAT_EXE);
    k = tracker.decoding[1] ? 8'($urandom_range(1, KEY_COUNT_DEF - 1)) : 8'd0;
    repeat ($urandom_range(3)) raw.push_back(8'($urandom));
    shape = $urandom_range(9);
    if (shape == 0) begin
      repeat (4) raw.push_back(8'($urandom));
    end else begin
      if (exe_side) word = '{".", "e", "x", "e"};
      else word = '{"h", "t", "t", "p"};
      foreach (word[i]) begin
        c = word[i];
        if (c != "." && $urandom_range(1) == 1) c = c - 8'd32;
        raw.push_back(encode(c, k, exe_side));
      end
      // break the pattern in one place
      if (shape == 1) raw[raw.size() - 1 - $urandom_range(3)] = 8'($urandom);
    end
    if (!exe_side)
      repeat ($urandom_range(6)) raw.push_back(encode(8'($urandom_range(33, 126)), k, 1'b0));
    ending = $urandom_range(9);
    closed = (ending != 9);
    if (ending < 7) begin
      c = ($urandom_range(1) == 1) ? 8'($urandom_range(32)) : 8'($urandom_range(127, 255));
      raw.push_back(encode(c, k, 1'b0));
      repeat ($urandom_range(2)) raw.push_back(8'($urandom));
    end
    foreach (raw[i]) send_byte(raw[i], i == 0, closed && i == raw.size() - 1);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_end;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Hand-picked sets under plain http search.
    // Match on the final byte: four letters, no end marker.
    send_text("HtTp", 1'b1, 1'b1);
    // Lowest and highest url characters, then DEL closes the url.
    send_text("http!~", 1'b1, 1'b0);
    send_byte(8'd127, 1'b0, 1'b1);
    // Printable url byte on the final byte: the letter and then the marker.
    send_text("hTTpZ", 1'b1, 1'b1);
    // End of data while scanning: no match may span the two sets.
    send_text("ht", 1'b1, 1'b1);
    send_text("tp", 1'b0, 1'b1);
    // Change the decoding in the middle of a url.
    send_text("httpq", 1'b1, 1'b0);
    settle();
    write_reg(REG_SCAN_DECODING, DEC_ROT13);
    send_byte("n", 1'b0, 1'b0);
    send_byte(8'd0, 1'b0, 1'b1);
    settle();

    // Random phases, each with its own setting and one of four idling patterns.
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_SCAN_DECODING, PHASE_DEC[p]);
      write_reg(REG_SEARCH_PATTERN, {1'b0, PHASE_PAT[p]});
      gap_pct   = GAP_PCT[p % 4];
      stall_pct = STALL_PCT[p % 4];
      // back-pressure: the receiver holds off while bytes keep coming
      if (p == 4) hold_requests++;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) send_record();
      settle();
    end

    if (tracker.pending.size() != 0) begin
      $error("%0d expected results never arrived", tracker.pending.size());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
